>>> hdl/ccsr_pkg.sv
// Shared types, widths and command codes of the character canvas rasteriser.
// No dependencies.
package ccsr_pkg;

  localparam int MaxColsDef = 64;
  localparam int MaxRowsDef = 64;

  localparam int OpW    = 3;
  localparam int PosW   = 11;
  localparam int SizeW  = 10;
  localparam int InkW   = 8;
  localparam int CoordW = 13;             // signed working width for positions
  localparam int SqW    = 21;             // one squared offset
  localparam int DistW  = 22;             // sum of two squared offsets
  localparam int RSqW   = 20;             // squared radius

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [OpW-1:0] {
    OP_BACKGROUND = 3'd0,
    OP_RECT_LINE  = 3'd1,
    OP_RECT_FILL  = 3'd2,
    OP_RING       = 3'd3,
    OP_READ       = 3'd4
  } op_e;

endpackage

>>> hdl/ccsr_canvas_ram.sv
// Canvas character store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module ccsr_canvas_ram #(
  parameter int Depth = 4096,
  parameter int AddrW = 12,
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/char_canvas_shape_rasterizer.sv
// Character canvas shape rasteriser: top level with command sequencer, pixel pipeline.
// Depends on ccsr_pkg and ccsr_canvas_ram.
// Read request: ST_RADDR reads the RAM, ST_RDATA loads the output register; the next request
//   is taken after ST_RDATA, which waits while the previous result still sits unread.
// Drawing and background requests: ST_SETUP, then ST_SWEEP tests one canvas cell per cycle,
//   writing each hit through the single RAM write port, then ST_DRAIN; ST_SETUP goes straight
//   back to idle when the canvas is empty. Unused codes are dropped at acceptance.
// Reset clears the sequencer, the output valid flag and the canvas size (reads report outside);
//   the canvas RAM itself is not cleared, the next background request fills it.
module char_canvas_shape_rasterizer
  import ccsr_pkg::*;
#(
  parameter int MAX_COLS = MaxColsDef,
  parameter int MAX_ROWS = MaxRowsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OpW-1:0]          operation_i,
  input  logic signed [PosW-1:0]  pos_x_i,
  input  logic signed [PosW-1:0]  pos_y_i,
  input  logic [SizeW-1:0]        size_w_i,
  input  logic [SizeW-1:0]        size_h_i,
  input  logic [SizeW-1:0]        radius_i,
  input  logic [InkW-1:0]         ink_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [InkW-1:0]         cell_char_o,
  output logic                    outside_canvas_o
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int Depth = MAX_COLS * MAX_ROWS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;       // RAM address
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1; // column index
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1; // row index
  localparam int CNW   = $clog2(MAX_COLS + 1);                  // column count
  localparam int RNW   = $clog2(MAX_ROWS + 1);                  // row count

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,  // precompute edges and squared radii
    ST_SWEEP = 6'b000100,  // issue one canvas cell per cycle
    ST_DRAIN = 6'b001000,  // let the pixel pipeline write its last cell
    ST_RADDR = 6'b010000,  // issue the RAM read for a read request
    ST_RDATA = 6'b100000   // read data back, load the output register
  } state_e;

  state_e state_q, state_d;

  // Canvas size, reset to an empty canvas
  logic [CNW-1:0] cols_q, cols_d;
  logic [RNW-1:0] rows_q, rows_d;

  // Captured request
  op_e                   op_q;
  logic signed [PosW-1:0] x_q, y_q;
  logic [SizeW-1:0]      w_q, h_q, radius_q;
  logic [InkW-1:0]       ink_q;

  // Per-request precomputed terms
  coord_t          xe_q, ye_q;       // x+w, y+h
  logic [RSqW-1:0] r_sq_q, rm1_sq_q; // r^2, (r-1)^2

  // Sweep counters
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [AW-1:0] addr_q, rowbase_q;

  // Pixel pipeline stage one
  logic           s1_valid_q;
  logic [AW-1:0]  s1_addr_q;
  logic           s1_hit_q;
  logic [SqW-1:0] s1_dx2_q, s1_dy2_q;

  // Output register
  logic            out_valid_q;
  logic [InkW-1:0] cell_char_q;
  logic            outside_q;
  logic            rd_outside_q;

  // RAM ports
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [InkW-1:0] ram_rdata;

  logic in_fire;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Signed views of the captured request
  // ---------------------------------------------------------------------------
  coord_t x13, y13, jc, ic, cols_c, rows_c;
  assign x13    = $signed({{(CoordW-PosW){x_q[PosW-1]}}, x_q});
  assign y13    = $signed({{(CoordW-PosW){y_q[PosW-1]}}, y_q});
  assign jc     = $signed(CoordW'(col_q));
  assign ic     = $signed(CoordW'(row_q));
  assign cols_c = $signed(CoordW'(cols_q));
  assign rows_c = $signed(CoordW'(rows_q));

  // ---------------------------------------------------------------------------
  // Cell test, first half: rectangle compares and the two squared offsets
  // ---------------------------------------------------------------------------
  logic   in_x, in_y, rect_line, cell_hit;
  coord_t dx, dy;
  logic signed [2*CoordW-1:0] dx_sq, dy_sq;

  always_comb begin
    in_x = (jc >= x13) && (jc < xe_q);
    in_y = (ic >= y13) && (ic < ye_q);
    // outline rules taken literally, so zero width or height still paints two lines
    rect_line = ((ic == y13) && in_x) ||
                ((ic + CoordW'(1) == ye_q) && in_x) ||
                ((jc == x13) && in_y) ||
                ((jc + CoordW'(1) == xe_q) && in_y);
    unique case (op_q)
      OP_BACKGROUND: cell_hit = 1'b1;
      OP_RECT_LINE:  cell_hit = rect_line;
      OP_RECT_FILL:  cell_hit = in_x && in_y;
      default:       cell_hit = 1'b0;  // ring decided in stage two
    endcase
    dx    = jc - x13;
    dy    = ic - y13;
    dx_sq = dx * dx;
    dy_sq = dy * dy;
  end

  // ---------------------------------------------------------------------------
  // Cell test, second half: ring band compare, then the write
  // ---------------------------------------------------------------------------
  logic [DistW-1:0] dist_sq;
  logic             ring_hit;
  assign dist_sq  = DistW'(s1_dx2_q) + DistW'(s1_dy2_q);
  assign ring_hit = (dist_sq > DistW'(rm1_sq_q)) && (dist_sq <= DistW'(r_sq_q));
  assign ram_we   = s1_valid_q && ((op_q == OP_RING) ? ring_hit : s1_hit_q);

  // ---------------------------------------------------------------------------
  // Setup terms
  // ---------------------------------------------------------------------------
  logic signed [PosW-1:0]   rm1;
  logic signed [2*PosW-1:0] rm1_prod;
  logic [2*SizeW-1:0]       r_prod;
  assign rm1      = $signed({1'b0, radius_q}) - PosW'(1);
  assign rm1_prod = rm1 * rm1;
  assign r_prod   = radius_q * radius_q;

  // ---------------------------------------------------------------------------
  // Read address (constant row pitch)
  // ---------------------------------------------------------------------------
  logic [AW-1:0] rd_row, rd_col;
  logic          rd_inside;
  assign rd_row    = AW'(y_q[RW-1:0]);
  assign rd_col    = AW'(x_q[CW-1:0]);
  assign ram_raddr = AW'(rd_row * AW'(MAX_COLS)) + rd_col;
  assign ram_re    = (state_q == ST_RADDR);
  assign rd_inside = (x13 >= 0) && (y13 >= 0) && (x13 < cols_c) && (y13 < rows_c);

  // Sweep end conditions
  logic last_col, last_row;
  assign last_col = (col_q == CW'(cols_q - CNW'(1)));
  assign last_row = (row_q == RW'(rows_q - RNW'(1)));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cols_d  = cols_q;
    rows_d  = rows_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          priority case (operation_i)
            OP_BACKGROUND: begin
              // saturate to the built canvas
              cols_d  = (32'(size_w_i) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(size_w_i);
              rows_d  = (32'(size_h_i) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(size_h_i);
              state_d = ST_SETUP;
            end
            OP_RECT_LINE, OP_RECT_FILL, OP_RING: state_d = ST_SETUP;
            OP_READ: state_d = ST_RADDR;
            default: state_d = ST_IDLE;  // unused codes are dropped
          endcase
        end
      end
      ST_SETUP: begin
        state_d = ((cols_q == '0) || (rows_q == '0)) ? ST_IDLE : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (last_col && last_row) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_RADDR: state_d = ST_RDATA;
      ST_RDATA: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cols_q     <= '0;
      rows_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cols_q     <= cols_d;
      rows_q     <= rows_d;
      s1_valid_q <= (state_q == ST_SWEEP);
    end
  end

  // Request capture, setup terms, sweep counters and pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= op_e'(operation_i);
      x_q      <= pos_x_i;
      y_q      <= pos_y_i;
      w_q      <= size_w_i;
      h_q      <= size_h_i;
      radius_q <= radius_i;
      ink_q    <= ink_i;
    end
    if (state_q == ST_SETUP) begin
      xe_q      <= x13 + $signed(CoordW'(w_q));
      ye_q      <= y13 + $signed(CoordW'(h_q));
      r_sq_q    <= r_prod[RSqW-1:0];
      rm1_sq_q  <= rm1_prod[RSqW-1:0];
      col_q     <= '0;
      row_q     <= '0;
      addr_q    <= '0;
      rowbase_q <= '0;
    end else if (state_q == ST_SWEEP) begin
      if (last_col) begin
        col_q     <= '0;
        row_q     <= row_q + RW'(1);
        rowbase_q <= rowbase_q + AW'(MAX_COLS);
        addr_q    <= rowbase_q + AW'(MAX_COLS);
      end else begin
        col_q  <= col_q + CW'(1);
        addr_q <= addr_q + AW'(1);
      end
    end
    s1_addr_q <= addr_q;
    s1_hit_q  <= cell_hit;
    s1_dx2_q  <= dx_sq[SqW-1:0];
    s1_dy2_q  <= dy_sq[SqW-1:0];
    if (state_q == ST_RADDR) begin
      rd_outside_q <= !rd_inside;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_RDATA) && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RDATA) && (!out_valid_q || out_ready_i)) begin
      cell_char_q <= rd_outside_q ? '0 : ram_rdata;
      outside_q   <= rd_outside_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cell_char_o      = cell_char_q;
  assign outside_canvas_o = outside_q;

  // ---------------------------------------------------------------------------
  // Canvas store
  // ---------------------------------------------------------------------------
  ccsr_canvas_ram #(
    .Depth(Depth),
    .AddrW(AW),
    .DataW(InkW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_addr_q),
    .wdata_i(ink_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SWEEP) || (state_q == ST_DRAIN))
    else $error("canvas write outside a sweep");

  a_sweep_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (CNW'(col_q) < cols_q) && (RNW'(row_q) < rows_q))
    else $error("sweep counter beyond canvas");

  a_addr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (addr_q == rowbase_q + AW'(col_q)))
    else $error("sweep address lost track of column");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RDATA))
    else $error("result without read request");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outside_canvas_o) |-> (cell_char_o == '0))
    else $error("outside read carries a character");

endmodule

>>> verif/tb_char_canvas_shape_rasterizer.sv
`timescale 1ns / 1ps
// Self-checking bench for char_canvas_shape_rasterizer: directed and random drawing and
// read requests, with every read result checked against a behavioural canvas model.
// Depends on ccsr_pkg and the rasteriser RTL.
module tb_char_canvas_shape_rasterizer;
  import ccsr_pkg::*;

  localparam int MaxCols        = MaxColsDef;
  localparam int MaxRows        = MaxRowsDef;
  localparam int RandomRequests = 110;
  // The final stretch of requests runs with no idling on either side.
  localparam int TailRequests   = 20;
  // Drain wait covers the longest request, a full-canvas pass through the pixel pipeline.
  localparam int DrainCycles    = MaxCols * MaxRows + 16;
  localparam logic [OpW-1:0] OpCodeTop = {OpW{1'b1}};

  typedef struct {
    logic [OpW-1:0]          op;
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic [SizeW-1:0]        size_w;
    logic [SizeW-1:0]        size_h;
    logic [SizeW-1:0]        radius;
    logic [InkW-1:0]         ink;
  } draw_cmd_t;

  typedef struct {
    logic [InkW-1:0] cell_char;
    logic            outside;
  } cell_read_t;

  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   in_valid_i       = 1'b0;
  logic                   in_ready_o;
  logic [OpW-1:0]         operation_i      = '0;
  logic signed [PosW-1:0] pos_x_i          = '0;
  logic signed [PosW-1:0] pos_y_i          = '0;
  logic [SizeW-1:0]       size_w_i         = '0;
  logic [SizeW-1:0]       size_h_i         = '0;
  logic [SizeW-1:0]       radius_i         = '0;
  logic [InkW-1:0]        ink_i            = '0;
  logic                   out_valid_o;
  logic                   out_ready_i      = 1'b0;
  logic [InkW-1:0]        cell_char_o;
  logic                   outside_canvas_o;

  draw_cmd_t  cmd_backlog[$];     // requests not yet offered to the block
  cell_read_t expected_reads[$];  // read results still owed by the block
  draw_cmd_t  presented;          // request currently held on the input port

  // Canvas model: cell (col,row) at row*MaxCols+col, same size as the block's store.
  logic [InkW-1:0] canvas_model [MaxCols*MaxRows] = '{default: '0};
  int model_cols = 0;
  int model_rows = 0;

  int mismatch_count = 0;
  int quiet_left     = 0;   // requests left in a stretch with no idling
  int valid_gap      = 0;
  int ready_hold     = 0;

  char_canvas_shape_rasterizer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .size_w_i         (size_w_i),
    .size_h_i         (size_h_i),
    .radius_i         (radius_i),
    .ink_i            (ink_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cell_char_o      (cell_char_o),
    .outside_canvas_o (outside_canvas_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic bit in_span(int p, int lo, int len);
    return p >= lo && p < lo + len;
  endfunction

  // One-cell outline, conditions taken literally so zero sizes give the doubled edges.
  function automatic bit on_outline(int j, int i, int x, int y, int w, int h);
    return (i == y && in_span(j, x, w)) || (i + 1 == y + h && in_span(j, x, w)) ||
           (j == x && in_span(i, y, h)) || (j + 1 == x + w && in_span(i, y, h));
  endfunction

  function automatic bit on_ring(int j, int i, int x, int y, int r);
    int d;
    d = (j - x) * (j - x) + (i - y) * (i - y);
    return d > (r - 1) * (r - 1) && d <= r * r;
  endfunction

  // Updates the canvas model for one accepted request; a read queues its expected result.
  task automatic apply_to_canvas(input draw_cmd_t c);
    int x, y, w, h, r;
    bit hit;
    cell_read_t rd;
    x = int'(c.pos_x);
    y = int'(c.pos_y);
    w = int'(c.size_w);
    h = int'(c.size_h);
    r = int'(c.radius);
    case (c.op)
      OP_BACKGROUND: begin
        model_cols = (w > MaxCols) ? MaxCols : w;
        model_rows = (h > MaxRows) ? MaxRows : h;
        for (int i = 0; i < model_rows; i++)
          for (int j = 0; j < model_cols; j++)
            canvas_model[i*MaxCols+j] = c.ink;
      end
      OP_RECT_LINE, OP_RECT_FILL, OP_RING: begin
        for (int i = 0; i < model_rows; i++) begin
          for (int j = 0; j < model_cols; j++) begin
            if (c.op == OP_RECT_LINE) hit = on_outline(j, i, x, y, w, h);
            else if (c.op == OP_RECT_FILL) hit = in_span(i, y, h) && in_span(j, x, w);
            else hit = on_ring(j, i, x, y, r);
            if (hit) canvas_model[i*MaxCols+j] = c.ink;
          end
        end
      end
      OP_READ: begin
        if (x >= 0 && y >= 0 && x < model_cols && y < model_rows) begin
          rd.cell_char = canvas_model[y*MaxCols+x];
          rd.outside   = 1'b0;
        end else begin
          rd.cell_char = '0;
          rd.outside   = 1'b1;
        end
        expected_reads.push_back(rd);
      end
      default: ;  // unused codes are dropped silently
    endcase
  endtask

  function automatic draw_cmd_t make_cmd(logic [OpW-1:0] op, int x, int y, int w, int h,
                                         int r, int ink);
    draw_cmd_t c;
    c.op     = op;
    c.pos_x  = PosW'(x);
    c.pos_y  = PosW'(y);
    c.size_w = SizeW'(w);
    c.size_h = SizeW'(h);
    c.radius = SizeW'(r);
    c.ink    = InkW'(ink);
    return c;
  endfunction

  // Every field random over its full range; callers narrow what matters.
  function automatic draw_cmd_t rand_cmd(logic [OpW-1:0] op);
    return make_cmd(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic bit idling_allowed();
    return cmd_backlog.size() > TailRequests && quiet_left == 0;
  endfunction

  // Request driver: holds each request until accepted, idles in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      valid_gap  = 0;
    end else begin
      if (in_valid_i && in_ready_o) apply_to_canvas(presented);
      if (!in_valid_i || in_ready_o) begin
        if (valid_gap > 0) begin
          valid_gap--;
          in_valid_i <= 1'b0;
        end else if (cmd_backlog.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
          valid_gap  = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else begin
          presented = cmd_backlog.pop_front();
          if (quiet_left > 0) quiet_left--;
          else if ($urandom_range(0, 24) == 0) quiet_left = $urandom_range(8, 24);
          operation_i <= presented.op;
          pos_x_i     <= presented.pos_x;
          pos_y_i     <= presented.pos_y;
          size_w_i    <= presented.size_w;
          size_h_i    <= presented.size_h;
          radius_i    <= presented.radius;
          ink_i       <= presented.ink;
          in_valid_i  <= 1'b1;
        end
      end
    end
  end

  // Result monitor: checks each accepted read result, stalls ready in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    cell_read_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_hold  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reads.size() == 0) begin
          report_mismatch("read result with no read request outstanding");
        end else begin
          want = expected_reads.pop_front();
          if (cell_char_o !== want.cell_char)
            report_mismatch($sformatf("cell_char %h, expected %h", cell_char_o,
                                      want.cell_char));
          if (outside_canvas_o !== want.outside)
            report_mismatch($sformatf("outside_canvas %b, expected %b", outside_canvas_o,
                                      want.outside));
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready_i <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        ready_hold  = $urandom_range(0, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    draw_cmd_t c;
    int gen_cols, gen_rows, span, counted, pick;

    // Directed: empty canvas after reset, zero-size and oversized backgrounds,
    // degenerate outlines, clipped fill, zero and huge radii, unused codes.
    cmd_backlog.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_BACKGROUND, 0, 0, 0, 0, 0, 8'h41));
    cmd_backlog.push_back(make_cmd(OP_READ, -1024, 1023, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_BACKGROUND, 1023, -1024, 1023, 1023, 1023, 8'hFF));
    cmd_backlog.push_back(make_cmd(OP_RECT_LINE, 2, 3, 5, 4, 0, 8'h23));
    cmd_backlog.push_back(make_cmd(OP_RECT_LINE, 10, 10, 0, 3, 0, 8'h61));
    cmd_backlog.push_back(make_cmd(OP_RECT_LINE, 20, 20, 4, 0, 0, 8'h62));
    cmd_backlog.push_back(make_cmd(OP_RECT_FILL, 60, 61, 1023, 1023, 0, 8'h00));
    cmd_backlog.push_back(make_cmd(OP_RING, 30, 30, 0, 0, 5, 8'h6F));
    cmd_backlog.push_back(make_cmd(OP_RING, 40, 40, 0, 0, 0, 8'h7A));
    // Radius at its top: the ring's right arc crosses columns 21 to 23.
    cmd_backlog.push_back(make_cmd(OP_RING, -1000, 10, 0, 0, 1023, 8'h71));
    cmd_backlog.push_back(make_cmd(OpW'(int'(OP_READ) + 1), 0, 0, 3, 3, 0, 8'h55));
    cmd_backlog.push_back(make_cmd(OpCodeTop, 0, 0, 3, 3, 0, 8'hAA));
    cmd_backlog.push_back(make_cmd(OP_READ, 2, 3, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_READ, 10, 11, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_READ, 9, 11, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_READ, 21, 19, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_READ, 63, 63, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_READ, 35, 30, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_READ, 40, 40, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_READ, 22, 20, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_READ, 64, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_READ, 0, -1, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_READ, 1023, 1023, 0, 0, 0, 0));

    // Random: each phase sets a canvas, then draws and reads on it. Canvases are
    // mostly small; a full-range background, usually saturating, is the slow case.
    counted = 0;
    while (counted < RandomRequests) begin
      c = rand_cmd(OP_BACKGROUND);
      pick = $urandom_range(0, 9);
      if (pick == 1) begin
        c.size_w = SizeW'($urandom_range(13, 48));
        c.size_h = SizeW'($urandom_range(13, 48));
      end else if (pick > 1) begin
        c.size_w = SizeW'($urandom_range(0, 12));
        c.size_h = SizeW'($urandom_range(0, 12));
      end
      gen_cols = (int'(c.size_w) > MaxCols) ? MaxCols : int'(c.size_w);
      gen_rows = (int'(c.size_h) > MaxRows) ? MaxRows : int'(c.size_h);
      span = (gen_cols > gen_rows) ? gen_cols : gen_rows;
      cmd_backlog.push_back(c);
      counted++;
      repeat ($urandom_range(4, 14)) begin
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
          c = rand_cmd(OpW'($urandom_range(int'(OP_RECT_LINE), int'(OP_RING))));
          // Mostly shapes around the canvas; the rest keep full-range fields.
          if ($urandom_range(0, 7) != 0) begin
            c.pos_x  = PosW'(int'($urandom_range(0, gen_cols + 8)) - 4);
            c.pos_y  = PosW'(int'($urandom_range(0, gen_rows + 8)) - 4);
            c.size_w = SizeW'($urandom_range(0, gen_cols + 4));
            c.size_h = SizeW'($urandom_range(0, gen_rows + 4));
            c.radius = SizeW'($urandom_range(0, span / 2 + 4));
          end
          counted++;
        end else if (pick < 19) begin
          c = rand_cmd(OP_READ);
          if ($urandom_range(0, 5) != 0) begin
            c.pos_x = PosW'(int'($urandom_range(0, gen_cols + 1)) - 1);
            c.pos_y = PosW'(int'($urandom_range(0, gen_rows + 1)) - 1);
          end
          counted++;
        end else begin
          c = rand_cmd(OpW'($urandom_range(int'(OP_READ) + 1, int'(OpCodeTop))));
        end
        cmd_backlog.push_back(c);
      end
    end

    while (cmd_backlog.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_reads.size() > 0) @(posedge clk_i);
    // Let a trailing drawing request finish and catch any stray result.
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // About 150 requests at worst a full-canvas pass plus both idle bursts each is
  // under 13 ms; the limit gives several times that.
  initial begin
    #80_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
